// ===== hw/rtl/window_hit_test_raise_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the window hit test and raise unit
// Shared property shapes, each reporting through $error.
// ----------------------------------------------------------------------------
`ifndef WINDOW_HIT_TEST_RAISE_UNIT_DEFINES_SVH
`define WINDOW_HIT_TEST_RAISE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define WHT_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wht: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define WHT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wht: next-cycle check failed");

`endif

// ===== hw/rtl/wht_pkg.sv =====
// ----------------------------------------------------------------------------
// wht_pkg
// Transaction types, opcodes and controller states of the window hit test unit.
// ----------------------------------------------------------------------------
package wht_pkg;

  localparam int COORD_W = 12;
  localparam int ID_W    = 5;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_CLICK = 1'b1;

  typedef struct packed {
    logic               op;
    logic [COORD_W-1:0] x_left;
    logic [COORD_W-1:0] y_bottom;
    logic [COORD_W-1:0] x_right;
    logic [COORD_W-1:0] y_top;
    logic [COORD_W-1:0] x_coord;
    logic [COORD_W-1:0] y_coord;
  } wht_cmd_t;

  typedef struct packed {
    logic            hit;
    logic [ID_W-1:0] window_id;
  } wht_result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT
  } wht_state_t;

endpackage

// ===== hw/rtl/wht_ram.sv =====
// ----------------------------------------------------------------------------
// wht_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module wht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/window_hit_test_raise_unit.sv =====
// Load: no result, busy stays low.
// Click with n windows: scanned top down, one entry per cycle out of the order RAM.
// Miss: result strobe once the bottom entry has been compared; hit: result strobe once the
// window is raised to the top, the raise being one order RAM read and write per moved entry.
// Click with no windows: result strobe in the next cycle. The next transaction may
// start in the strobe cycle. Synchronous reset empties the stack; RAMs are not cleared.
// ----------------------------------------------------------------------------
// window_hit_test_raise_unit
// Z-ordered window stack with click hit test and raise to top.
// ----------------------------------------------------------------------------
`include "window_hit_test_raise_unit_defines.svh"

module window_hit_test_raise_unit
  import wht_pkg::*;
#(
  parameter int MAX_WINDOWS = 16,
  parameter int COORD_BITS  = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  wht_cmd_t    cmd,
  output logic        busy,
  output logic        done,
  output wht_result_t result
);

  localparam int AW     = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
  localparam int CW     = $clog2(MAX_WINDOWS + 1);
  localparam int RW     = 4 * COORD_BITS;
  localparam int XW     = (COORD_BITS > COORD_W) ? COORD_BITS : COORD_W;
  localparam int EXT_W  = (CW > ID_W) ? CW : ID_W;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_WINDOWS);

  function automatic logic [COORD_BITS-1:0] take_coord(input logic [COORD_W-1:0] v);
    logic [XW-1:0] wide;
    wide = XW'(v);
    return wide[COORD_BITS-1:0];
  endfunction

  function automatic logic point_inside(input logic [RW-1:0] r,
                                        input logic [COORD_BITS-1:0] x,
                                        input logic [COORD_BITS-1:0] y);
    logic [COORD_BITS-1:0] xl, yb, xr, yt;
    xl = r[0*COORD_BITS +: COORD_BITS];
    yb = r[1*COORD_BITS +: COORD_BITS];
    xr = r[2*COORD_BITS +: COORD_BITS];
    yt = r[3*COORD_BITS +: COORD_BITS];
    return (x >= xl) && (x <= xr) && (y >= yb) && (y <= yt);
  endfunction

  // Registers
  wht_state_t      state, state_next;
  logic [CW-1:0]   count, count_next;
  logic [COORD_BITS-1:0] px, px_next, py, py_next;
  logic [AW-1:0]   issue_pos, issue_pos_next;
  logic            issue_more, issue_more_next;
  logic            s1_vld, s1_vld_next;
  logic [AW-1:0]   s1_pos, s1_pos_next;
  logic            s2_vld, s2_vld_next;
  logic [AW-1:0]   s2_pos, s2_pos_next;
  logic [CW-1:0]   s2_id, s2_id_next;
  logic [CW-1:0]   hit_id, hit_id_next;
  logic [CW-1:0]   sh_pos, sh_pos_next;
  logic            sh_wvld, sh_wvld_next;
  logic [AW-1:0]   sh_wpos, sh_wpos_next;
  logic            done_next;
  wht_result_t     result_next;

  // Memory ports
  logic            order_we;
  logic [AW-1:0]   order_waddr, order_raddr;
  logic [CW-1:0]   order_wdata, order_rdata;
  logic            rect_we;
  logic [RW-1:0]   rect_wdata, rect_rdata;
  logic [AW-1:0]   rect_raddr;

  logic [CW-1:0]    cnt_m1, id_m1, sh_pos_m1, hit_pos_ext;
  logic [EXT_W-1:0] s2_id_ext;
  logic             in_rect, sh_read;

  wht_ram #(.WIDTH(CW), .DEPTH(MAX_WINDOWS)) u_order_ram (
    .clk   (clk),
    .we    (order_we),
    .waddr (order_waddr),
    .wdata (order_wdata),
    .raddr (order_raddr),
    .rdata (order_rdata)
  );

  wht_ram #(.WIDTH(RW), .DEPTH(MAX_WINDOWS)) u_rect_ram (
    .clk   (clk),
    .we    (rect_we),
    .waddr (count[AW-1:0]),
    .wdata (rect_wdata),
    .raddr (rect_raddr),
    .rdata (rect_rdata)
  );

  assign busy        = (state != ST_IDLE);
  assign cnt_m1      = count - 1'b1;
  assign id_m1       = order_rdata - 1'b1;
  assign sh_pos_m1   = sh_pos - 1'b1;
  assign hit_pos_ext = CW'(s2_pos);
  assign s2_id_ext   = EXT_W'(s2_id);
  assign rect_raddr  = id_m1[AW-1:0];
  assign rect_wdata  = {take_coord(cmd.y_top), take_coord(cmd.x_right),
                        take_coord(cmd.y_bottom), take_coord(cmd.x_left)};
  assign in_rect     = point_inside(rect_rdata, px, py);
  assign sh_read     = (sh_pos < count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      issue_more <= 1'b0;
      s1_vld     <= 1'b0;
      s2_vld     <= 1'b0;
      sh_wvld    <= 1'b0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      issue_more <= issue_more_next;
      s1_vld     <= s1_vld_next;
      s2_vld     <= s2_vld_next;
      sh_wvld    <= sh_wvld_next;
      done       <= done_next;
    end
    px        <= px_next;
    py        <= py_next;
    issue_pos <= issue_pos_next;
    s1_pos    <= s1_pos_next;
    s2_pos    <= s2_pos_next;
    s2_id     <= s2_id_next;
    hit_id    <= hit_id_next;
    sh_pos    <= sh_pos_next;
    sh_wpos   <= sh_wpos_next;
    result    <= result_next;
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    px_next         = px;
    py_next         = py;
    issue_pos_next  = issue_pos;
    issue_more_next = issue_more;
    s1_vld_next     = 1'b0;
    s1_pos_next     = s1_pos;
    s2_vld_next     = 1'b0;
    s2_pos_next     = s2_pos;
    s2_id_next      = s2_id;
    hit_id_next     = hit_id;
    sh_pos_next     = sh_pos;
    sh_wvld_next    = 1'b0;
    sh_wpos_next    = sh_wpos;
    done_next       = 1'b0;
    result_next     = result;
    order_we        = 1'b0;
    order_waddr     = count[AW-1:0];
    order_wdata     = count + 1'b1;
    order_raddr     = issue_pos;
    rect_we         = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (cmd.op == OP_CLICK) begin
            px_next = take_coord(cmd.x_coord);
            py_next = take_coord(cmd.y_coord);
            if (count == '0) begin
              done_next   = 1'b1;
              result_next = '0;
            end else begin
              issue_pos_next  = cnt_m1[AW-1:0];
              issue_more_next = 1'b1;
              state_next      = ST_SCAN;
            end
          end else if (count < MAX_CNT) begin
            order_we   = 1'b1;
            rect_we    = 1'b1;
            count_next = count + 1'b1;
          end
        end
      end

      ST_SCAN: begin
        // Stage 0 reads the order RAM, stage 1 the rectangle, stage 2 compares.
        s1_vld_next = issue_more;
        s1_pos_next = issue_pos;
        if (issue_pos == '0) begin
          issue_more_next = 1'b0;
        end else begin
          issue_pos_next = issue_pos - 1'b1;
        end
        s2_vld_next = s1_vld;
        s2_pos_next = s1_pos;
        s2_id_next  = order_rdata;
        if (s2_vld) begin
          if (in_rect) begin
            hit_id_next     = s2_id;
            sh_pos_next     = hit_pos_ext + 1'b1;
            result_next.hit = 1'b1;
            result_next.window_id = s2_id_ext[ID_W-1:0];
            issue_more_next = 1'b0;
            s1_vld_next     = 1'b0;
            s2_vld_next     = 1'b0;
            state_next      = ST_SHIFT;
          end else if (s2_pos == '0) begin
            done_next       = 1'b1;
            result_next     = '0;
            issue_more_next = 1'b0;
            s1_vld_next     = 1'b0;
            s2_vld_next     = 1'b0;
            state_next      = ST_IDLE;
          end
        end
      end

      ST_SHIFT: begin
        // Entries above the hit move down one place; each entry read is written back while the next read is issued.
        if (sh_read) begin
          order_raddr  = sh_pos[AW-1:0];
          sh_pos_next  = sh_pos + 1'b1;
          sh_wvld_next = 1'b1;
          sh_wpos_next = sh_pos_m1[AW-1:0];
        end
        if (sh_wvld) begin
          order_we    = 1'b1;
          order_waddr = sh_wpos;
          order_wdata = order_rdata;
        end else if (!sh_read) begin
          order_we    = 1'b1;
          order_waddr = cnt_m1[AW-1:0];
          order_wdata = hit_id;
          done_next   = 1'b1;
          state_next  = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `WHT_ASSERT_NOW(a_done_when_idle, clk, rst, done, !busy)
  `WHT_ASSERT_NOW(a_miss_id_zero, clk, rst, done && !result.hit, result.window_id == '0)
  `WHT_ASSERT_NOW(a_scan_nonempty, clk, rst, state == ST_SCAN, count != '0)
  `WHT_ASSERT_NOW(a_last_entry_ends_issue, clk, rst,
                  state == ST_SCAN && s2_vld && s2_pos == '0, !issue_more && !s1_vld)
  `WHT_ASSERT_NEXT(a_click_progress, clk, rst, start && !busy && cmd.op == OP_CLICK,
                   busy || done)

endmodule
